@@ rtl/jtc_pkg.sv @@
// Shared types and constants for the JJY time code frame encoder.
// No dependencies.
package jtc_pkg;

  localparam int unsigned FrameLen = 60;
  localparam int unsigned PosW     = 6;
  localparam int unsigned TicksW   = 7;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

  localparam logic [CfgIdxW-1:0] CfgWidthZero   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidthOne    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWidthMarker = 2'd2;

  localparam logic [TicksW-1:0] RstWidthZero   = 7'd80;
  localparam logic [TicksW-1:0] RstWidthOne    = 7'd50;
  localparam logic [TicksW-1:0] RstWidthMarker = 7'd20;

  typedef enum logic [1:0] {
    KindZero = 2'd0,
    KindOne  = 2'd1,
    KindMark = 2'd2
  } kind_e;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [8:0] day_index;
    logic [6:0] year_of_century;
    logic [2:0] weekday;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        symbol_kind;
    logic [TicksW-1:0] pulse_ticks;
    logic [PosW-1:0]   second_position;
    logic              last_in_frame;
  } out_word_t;

  typedef struct packed {
    logic [TicksW-1:0] width_zero;
    logic [TicksW-1:0] width_one;
    logic [TicksW-1:0] width_marker;
  } widths_t;

  typedef kind_e [FrameLen-1:0] frame_t;

endpackage

@@ rtl/jtc_encoder.sv @@
// Clamps one time stamp and lays out the sixty symbol kinds of its frame.
// Depends on jtc_pkg.
module jtc_encoder import jtc_pkg::*; (
  input  in_word_t in_word_i,
  output frame_t   frame_o
);

  // greedy 80/40/20/10 then remainder: tens and units of a value below 100
  function automatic logic [7:0] to_bcd2(input logic [6:0] v);
    logic [6:0] rest;
    logic [3:0] tens;
    rest = v;
    tens = '0;
    for (int i = 3; i >= 0; i--) begin
      if (rest >= 7'(10 << i)) begin
        rest = rest - 7'(10 << i);
        tens[i] = 1'b1;
      end
    end
    return {tens, rest[3:0]};
  endfunction

  function automatic kind_e bit_kind(input logic b);
    return b ? KindOne : KindZero;
  endfunction

  logic [5:0] minute;
  logic [4:0] hour;
  logic [8:0] day_num;
  logic [6:0] year;
  logic [2:0] wday;
  logic       hund1;
  logic       hund0;
  logic [8:0] day_r1;
  logic [8:0] day_r2;
  logic [7:0] min_bcd;
  logic [7:0] hour_bcd;
  logic [7:0] day_bcd;
  logic [7:0] year_bcd;

  always_comb begin
    minute  = (in_word_i.minute > 6'd59) ? 6'd59 : in_word_i.minute;
    hour    = (in_word_i.hour > 5'd23) ? 5'd23 : in_word_i.hour;
    day_num = ((in_word_i.day_index > 9'd365) ? 9'd365 : in_word_i.day_index) + 9'd1;
    year    = (in_word_i.year_of_century > 7'd99) ? 7'd99 : in_word_i.year_of_century;
    wday    = (in_word_i.weekday > 3'd6) ? 3'd6 : in_word_i.weekday;

    hund1  = day_num >= 9'd200;
    day_r1 = hund1 ? day_num - 9'd200 : day_num;
    hund0  = day_r1 >= 9'd100;
    day_r2 = hund0 ? day_r1 - 9'd100 : day_r1;

    min_bcd  = to_bcd2({1'b0, minute});
    hour_bcd = to_bcd2({2'b00, hour});
    day_bcd  = to_bcd2(day_r2[6:0]);
    year_bcd = to_bcd2(year);
  end

  always_comb begin
    for (int i = 0; i < FrameLen; i++) begin
      frame_o[i] = KindZero;
    end
    frame_o[0]  = KindMark;
    frame_o[9]  = KindMark;
    frame_o[19] = KindMark;
    frame_o[29] = KindMark;
    frame_o[39] = KindMark;
    frame_o[49] = KindMark;
    frame_o[59] = KindMark;
    // minute
    for (int i = 0; i < 3; i++) frame_o[3-i] = bit_kind(min_bcd[4+i]);
    for (int i = 0; i < 4; i++) frame_o[8-i] = bit_kind(min_bcd[i]);
    // hour
    for (int i = 0; i < 2; i++) frame_o[13-i] = bit_kind(hour_bcd[4+i]);
    for (int i = 0; i < 4; i++) frame_o[18-i] = bit_kind(hour_bcd[i]);
    // day of year, plus one
    frame_o[22] = bit_kind(hund1);
    frame_o[23] = bit_kind(hund0);
    for (int i = 0; i < 4; i++) frame_o[28-i] = bit_kind(day_bcd[4+i]);
    for (int i = 0; i < 4; i++) frame_o[33-i] = bit_kind(day_bcd[i]);
    // even parity
    frame_o[36] = bit_kind(^{hour_bcd[5:4], hour_bcd[3:0]});
    frame_o[37] = bit_kind(^{min_bcd[6:4], min_bcd[3:0]});
    // year
    for (int i = 0; i < 4; i++) frame_o[44-i] = bit_kind(year_bcd[4+i]);
    for (int i = 0; i < 4; i++) frame_o[48-i] = bit_kind(year_bcd[i]);
    // weekday
    for (int i = 0; i < 3; i++) frame_o[52-i] = bit_kind(wday[i]);
  end

endmodule

@@ rtl/jtc_sequencer.sv @@
// Frame shift register, position counter and output register.
// Depends on jtc_pkg.
module jtc_sequencer import jtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  frame_t    frame_i,
  output logic      ready_o,
  input  widths_t   widths_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  frame_t          frame_q;
  logic            busy_q;
  logic [PosW-1:0] pos_q;
  logic            out_valid_q;
  out_word_t       out_q;
  logic            advance;
  logic            at_last;
  logic [TicksW-1:0] ticks;

  assign advance = busy_q && (!out_valid_q || out_ready_i);
  assign at_last = pos_q == LastPos;
  assign ready_o = !busy_q || (advance && at_last);

  always_comb begin
    unique case (frame_q[0])
      KindMark: ticks = widths_i.width_marker;
      KindOne:  ticks = widths_i.width_one;
      default:  ticks = widths_i.width_zero;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (advance) begin
        pos_q <= pos_q + PosW'(1);
        if (at_last) begin
          busy_q <= 1'b0;
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end else if (advance) begin
      for (int i = 0; i < FrameLen - 1; i++) begin
        frame_q[i] <= frame_q[i+1];
      end
    end
    if (advance) begin
      out_q.symbol_kind     <= frame_q[0];
      out_q.pulse_ticks     <= ticks;
      out_q.second_position <= pos_q;
      out_q.last_in_frame   <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/jjy_time_code_frame_encoder.sv @@
// JJY time code frame encoder, top level: width registers and datapath.
// The first symbol word is registered after the time stamp is loaded.
// Throughput: one symbol word per cycle while the receiver does not stall, set by the
// frame shift register; the next time stamp is taken as the last symbol moves out.
// Reset: widths return to 80/50/20 ticks, no frame in flight, output invalid.
// Depends on jtc_pkg, jtc_encoder, jtc_sequencer.
module jjy_time_code_frame_encoder import jtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TicksW-1:0]  cfg_wdata_i
);

  widths_t widths_q;
  frame_t  frame;
  logic    seq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widths_q.width_zero   <= RstWidthZero;
      widths_q.width_one    <= RstWidthOne;
      widths_q.width_marker <= RstWidthMarker;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWidthZero:   widths_q.width_zero   <= cfg_wdata_i;
        CfgWidthOne:    widths_q.width_one    <= cfg_wdata_i;
        CfgWidthMarker: widths_q.width_marker <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  jtc_encoder u_encoder (
    .in_word_i (in_word_i),
    .frame_o   (frame)
  );

  jtc_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_valid_i && seq_ready),
    .frame_i     (frame),
    .ready_o     (seq_ready),
    .widths_i    (widths_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  assign in_ready_o = seq_ready;

endmodule

@@ rtl/jtc_checker.sv @@
// Port-level checks on the frame encoder output, bound to the top level.
// Depends on jtc_pkg and jjy_time_code_frame_encoder.
module jtc_checker import jtc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  logic [PosW-1:0] pos;
  logic            mark_pos;

  assign pos      = out_word_o.second_position;
  assign mark_pos = (pos == 6'd0) || (pos == 6'd9) || (pos == 6'd19) || (pos == 6'd29) ||
                    (pos == 6'd39) || (pos == 6'd49) || (pos == 6'd59);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.last_in_frame == (pos == LastPos)))
    else $error("last flag does not match position");

  a_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mark_pos == (out_word_o.symbol_kind == KindMark)))
    else $error("marker at wrong position");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (pos != LastPos) ##1 out_valid_o |->
      (pos == $past(pos) + PosW'(1)))
    else $error("symbol position out of order");

endmodule

bind jjy_time_code_frame_encoder jtc_checker u_jtc_checker (.*);

@@ tb/tb_jjy_time_code_frame_encoder.sv @@
// Testbench for jjy_time_code_frame_encoder: sends time stamps, checks every
// symbol word of each frame against its own frame predictor or a given frame text.
// Depends on jtc_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_jjy_time_code_frame_encoder;
  import jtc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int CycleLimit = 600000;
  localparam int PhaseItems = 60;

  localparam int MinuteWt [8]  = '{40, 20, 10, 0, 8, 4, 2, 1};
  localparam int MinParWt [7]  = '{40, 20, 10, 8, 4, 2, 1};
  localparam int HourWt [9]    = '{0, 0, 20, 10, 0, 8, 4, 2, 1};
  localparam int HourParWt [6] = '{20, 10, 8, 4, 2, 1};
  localparam int DayWt [14]    = '{0, 0, 200, 100, 0, 80, 40, 20, 10, -1, 8, 4, 2, 1};
  localparam int YearWt [9]    = '{0, 80, 40, 20, 10, 8, 4, 2, 1};
  localparam int WdayWt [3]    = '{4, 2, 1};

  typedef kind_e kinds_q_t[$];

  typedef struct {
    in_word_t stamp;
    string    frame_text;
  } stamp_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_word_t           in_word_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_word_t          out_word_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgWidthZero;
  logic [TicksW-1:0]  cfg_wdata_i = '0;

  widths_t    widths;
  out_word_t  pending_symbols[$];
  stamp_row_t stamp_table[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         burst_left = 0;
  logic [1:0] stall_mode = 2'd0;
  logic [7:0] stall_tick = '0;
  string      zero_frame, top_frame;

  jjy_time_code_frame_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // greedy BCD step; negative weight is an embedded marker
  function automatic kind_e bcd_bit(inout int rest, input int wt);
    if (wt < 0) return KindMark;
    if (wt > 0 && rest >= wt) begin
      rest -= wt;
      return KindOne;
    end
    return KindZero;
  endfunction

  function automatic kinds_q_t jjy_frame_kinds(in_word_t w);
    kinds_q_t k;
    int mi, hr, dy, yr, wd, rest, ones;
    mi = (w.minute > 59) ? 59 : int'(w.minute);
    hr = (w.hour > 23) ? 23 : int'(w.hour);
    dy = (w.day_index > 365) ? 365 : int'(w.day_index);
    yr = (w.year_of_century > 99) ? 99 : int'(w.year_of_century);
    wd = (w.weekday > 6) ? 6 : int'(w.weekday);
    k.push_back(KindMark);
    rest = mi;
    foreach (MinuteWt[i]) k.push_back(bcd_bit(rest, MinuteWt[i]));
    k.push_back(KindMark);
    rest = hr;
    foreach (HourWt[i]) k.push_back(bcd_bit(rest, HourWt[i]));
    k.push_back(KindMark);
    rest = dy + 1;
    foreach (DayWt[i]) k.push_back(bcd_bit(rest, DayWt[i]));
    k.push_back(KindZero);
    k.push_back(KindZero);
    rest = hr;
    ones = 0;
    foreach (HourParWt[i]) if (bcd_bit(rest, HourParWt[i]) == KindOne) ones++;
    k.push_back(ones[0] ? KindOne : KindZero);
    rest = mi;
    ones = 0;
    foreach (MinParWt[i]) if (bcd_bit(rest, MinParWt[i]) == KindOne) ones++;
    k.push_back(ones[0] ? KindOne : KindZero);
    k.push_back(KindZero);
    k.push_back(KindMark);
    rest = yr;
    foreach (YearWt[i]) k.push_back(bcd_bit(rest, YearWt[i]));
    k.push_back(KindMark);
    rest = wd;
    foreach (WdayWt[i]) k.push_back(bcd_bit(rest, WdayWt[i]));
    repeat (6) k.push_back(KindZero);
    k.push_back(KindMark);
    return k;
  endfunction

  function automatic kinds_q_t kinds_from_text(string t);
    kinds_q_t k;
    for (int i = 0; i < FrameLen; i++) begin
      if (t[i] == "M") k.push_back(KindMark);
      else if (t[i] == "1") k.push_back(KindOne);
      else k.push_back(KindZero);
    end
    return k;
  endfunction

  function automatic void queue_frame(kinds_q_t k);
    out_word_t o;
    for (int s = 0; s < FrameLen; s++) begin
      o.symbol_kind     = k[s];
      o.pulse_ticks     = (k[s] == KindMark) ? widths.width_marker :
                          (k[s] == KindOne)  ? widths.width_one : widths.width_zero;
      o.second_position = PosW'(s);
      o.last_in_frame   = (s == FrameLen - 1);
      pending_symbols.push_back(o);
    end
  endfunction

  function automatic in_word_t make_stamp(int mi, int hr, int dy, int yr, int wd);
    in_word_t w;
    w.minute          = 6'(mi);
    w.hour            = 5'(hr);
    w.day_index       = 9'(dy);
    w.year_of_century = 7'(yr);
    w.weekday         = 3'(wd);
    return w;
  endfunction

  function automatic in_word_t random_stamp();
    if ($urandom_range(0, 6) == 0) return in_word_t'($urandom);
    return make_stamp($urandom_range(0, 59), $urandom_range(0, 23), $urandom_range(0, 365),
                      $urandom_range(0, 99), $urandom_range(0, 6));
  endfunction

  task automatic add_row(in_word_t w, string t);
    stamp_row_t row;
    row.stamp      = w;
    row.frame_text = t;
    stamp_table.push_back(row);
  endtask

  task automatic send_time_stamp(in_word_t w, string t);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 10))
        @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (t.len() == FrameLen) queue_frame(kinds_from_text(t));
    else queue_frame(jjy_frame_kinds(w));
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic drain_frames();
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_width(logic [CfgIdxW-1:0] idx, logic [TicksW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CfgWidthZero:   widths.width_zero   = v;
      CfgWidthOne:    widths.width_one    = v;
      CfgWidthMarker: widths.width_marker = v;
      default: ;
    endcase
  endtask

  task automatic set_widths(int z, int o, int m);
    drain_frames();
    write_width(CfgWidthZero, TicksW'(z));
    write_width(CfgUnused, TicksW'($urandom));
    write_width(CfgWidthOne, TicksW'(o));
    write_width(CfgWidthMarker, TicksW'(m));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 29) == 0) drain_frames();
      send_time_stamp(random_stamp(), "");
    end
  endtask

  initial begin
    widths.width_zero   = RstWidthZero;
    widths.width_one    = RstWidthOne;
    widths.width_marker = RstWidthMarker;
    zero_frame = {"M", "00000000", "M", "000000000", "M", "000000000", "M", "0001",
                  "00", "0", "0", "0", "M", "000000000", "M", "000", "000000", "M"};
    top_frame  = {"M", "10101001", "M", "001000011", "M", "001100110", "M", "0110",
                  "00", "1", "0", "0", "M", "010011001", "M", "110", "000000", "M"};
    add_row(make_stamp(0, 0, 0, 0, 0), zero_frame);
    add_row(make_stamp(59, 23, 365, 99, 6), top_frame);
    add_row(make_stamp(63, 31, 511, 127, 7), top_frame);
    add_row(make_stamp(60, 24, 366, 100, 7), top_frame);
    add_row(make_stamp(39, 19, 8, 79, 1), "");
    add_row(make_stamp(40, 20, 9, 80, 2), "");
    add_row(make_stamp(9, 9, 98, 9, 3), "");
    add_row(make_stamp(10, 10, 99, 10, 4), "");
    add_row(make_stamp(19, 11, 198, 19, 5), "");
    add_row(make_stamp(20, 12, 199, 20, 6), "");
    add_row(make_stamp(30, 21, 298, 50, 0), "");
    add_row(make_stamp(45, 22, 299, 63, 5), "");
    add_row(make_stamp(1, 1, 364, 1, 1), "");
    add_row(make_stamp(58, 3, 255, 64, 4), "");
    add_row(make_stamp(32, 16, 256, 32, 2), "");
    add_row(make_stamp(42, 21, 170, 85, 5), "");
    add_row(make_stamp(21, 10, 341, 42, 2), "");

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stamp_table[i]) send_time_stamp(stamp_table[i].stamp, stamp_table[i].frame_text);
    run_random(PhaseItems);
    set_widths(127, 127, 127);
    run_random(PhaseItems);
    set_widths(0, 0, 0);
    run_random(PhaseItems);
    set_widths(0, 127, 1);
    run_random(PhaseItems);
    set_widths($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
    run_random(PhaseItems);
    set_widths($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
    run_random(PhaseItems);

    drain_frames();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_symbols.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver: a new stall pattern is drawn each time the stall tick counter wraps
  always @(posedge clk_i) begin
    out_word_t exp_w;
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick == 8'hff) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready_i <= (stall_tick[3:0] < 4'd5);
      default: out_ready_i <= stall_tick[6];
    endcase
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_symbols.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: kind %0d ticks %0d pos %0d last %0d",
                   out_word_o.symbol_kind, out_word_o.pulse_ticks,
                   out_word_o.second_position, out_word_o.last_in_frame);
      end else begin
        exp_w = pending_symbols.pop_front();
        if (out_word_o !== exp_w) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch (exp/got): kind %0d/%0d ticks %0d/%0d pos %0d/%0d last %0d/%0d",
                     exp_w.symbol_kind, out_word_o.symbol_kind,
                     exp_w.pulse_ticks, out_word_o.pulse_ticks,
                     exp_w.second_position, out_word_o.second_position,
                     exp_w.last_in_frame, out_word_o.last_in_frame);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

@@ jjy_time_code_frame_encoder.f @@
rtl/jtc_pkg.sv
rtl/jtc_encoder.sv
rtl/jtc_sequencer.sv
rtl/jjy_time_code_frame_encoder.sv
rtl/jtc_checker.sv
tb/tb_jjy_time_code_frame_encoder.sv
